[hdl/cld_pkg.sv]
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types, constants and helpers of the content-length deframer.
// ----------------------------------------------------------------------------
package cld_pkg;

    // Width of the parsed length and of the saturating digit accumulator
    localparam int LENGTH_BITS  = 24;
    localparam int ACC_W        = LENGTH_BITS + 1;

    // Default longest line, terminator included
    localparam int LINE_MAX_DEF = 512;

    // Header prefix "Content-Length:"
    localparam int PREFIX_LEN   = 15;
    localparam int PREFIX_IDX_W = 4;

    // Special characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS   = 8'h20;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HDR_DONE   = 2'd0,
        KIND_BODY       = 2'd1,
        KIND_BAD_LEN    = 2'd2,
        KIND_STREAM_END = 2'd3
    } t_kind;

    // Message phase
    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } t_phase;

    // Number parser stage of a length line
    typedef enum logic [1:0] {
        NS_SKIP   = 2'd0,
        NS_SIGN   = 2'd1,
        NS_DIGITS = 2'd2,
        NS_STOP   = 2'd3
    } t_num_stage;

    // One input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_item;

    // One result beat
    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             body_byte;
        logic [LENGTH_BITS-1:0] body_length;
        logic                   last;
    } t_result;

    // ASCII upper to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

    // Lower-case prefix character at a position
    function automatic logic [7:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0:    r = 8'h63; // c
            4'd1:    r = 8'h6F; // o
            4'd2:    r = 8'h6E; // n
            4'd3:    r = 8'h74; // t
            4'd4:    r = 8'h65; // e
            4'd5:    r = 8'h6E; // n
            4'd6:    r = 8'h74; // t
            4'd7:    r = 8'h2D; // -
            4'd8:    r = 8'h6C; // l
            4'd9:    r = 8'h65; // e
            4'd10:   r = 8'h6E; // n
            4'd11:   r = 8'h67; // g
            4'd12:   r = 8'h74; // t
            4'd13:   r = 8'h68; // h
            4'd14:   r = 8'h3A; // :
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[hdl/content_length_deframer_core.sv]
// ----------------------------------------------------------------------------
// content_length_deframer_core
// Splits a byte stream into messages framed by a "Content-Length:" header.
//
//  Channel   Dir  tdata                               tuser          tlast
//  s_axis    in   [7:0] in_byte                       stream_end     -
//  m_axis    out  [7:0] body_byte, [31:8] body_length [1:0] kind     last
//
// One beat per clock while m_axis does not stall: input register, parse logic,
// result register, in that order, before a beat's result shows on m_axis.
// Header bytes other than an empty line or a stream end give no result beat.
// Reset is synchronous, active low, and starts a fresh header.
// A stall on m_axis holds the result register and backs up into s_axis
// once the input register is full; no beat is dropped.
// ----------------------------------------------------------------------------
module content_length_deframer_core
    import cld_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tuser,   // [0] stream_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] body_byte, [31:8] body_length
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last
);

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_vld;
    logic    w_take;
    logic    w_out_free;
    logic    w_res_vld;
    t_result w_res;
    t_result w_out_res;
    t_phase  w_phase;

    assign w_in_item.in_byte    = i_s_axis_tdata;
    assign w_in_item.stream_end = i_s_axis_tuser;

    // Hand the held beat to the parser when the result register has room
    assign w_take = w_item_vld && w_out_free;

    cld_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_item_vld),
        .o_item  (w_item)
    );

    cld_parser #(
        .LINE_MAX (LINE_MAX)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_item    (w_item),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .o_phase   (w_phase)
    );

    cld_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_vld),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out_res)
    );

    // Pack the result beat
    assign o_m_axis_tdata = {w_out_res.body_length, w_out_res.body_byte};
    assign o_m_axis_tuser = w_out_res.kind;
    assign o_m_axis_tlast = w_out_res.last;

    // A held beat that is not taken stays in the input register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_vld && !w_take |=> w_item_vld)
        else $error("input beat lost while stalled");

    // A stream end always returns the parser to the header phase
    a_end_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_item.stream_end |=> w_phase == PH_HEADER)
        else $error("stream end did not restart the header");

    // A produced result shows up on the master side next cycle
    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |=> o_m_axis_tvalid)
        else $error("result beat not presented");

    // No result is produced while the output register is full and stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !w_res_vld)
        else $error("result register overwritten");

endmodule

[hdl/cld_in_stage.sv]
// ----------------------------------------------------------------------------
// cld_in_stage
// Input register: captures one beat from the slave side and holds it until
// the parser takes it.
// ----------------------------------------------------------------------------
module cld_in_stage
    import cld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_vld;
    t_item r_item;

    // Free when empty or when the held beat leaves this cycle
    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[hdl/cld_parser.sv]
// ----------------------------------------------------------------------------
// cld_parser
// Header and body state machine: one input beat updates the parse state and
// yields at most one result.
// ----------------------------------------------------------------------------
module cld_parser
    import cld_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_item   i_item,
    output logic    o_res_vld,
    output t_result o_res,
    output t_phase  o_phase
);

    localparam int COL_W = $clog2(LINE_MAX);
    localparam logic [COL_W-1:0]   COL_LAST    = COL_W'(LINE_MAX - 1);
    localparam logic [COL_W-1:0]   PREFIX_COL  = COL_W'(PREFIX_LEN);
    localparam logic [ACC_W-1:0]   ACC_SAT     = {1'b1, {LENGTH_BITS{1'b0}}};
    localparam int                 MUL_W       = ACC_W + 3;
    localparam logic [MUL_W-1:0]   MUL_SAT     = MUL_W'(ACC_SAT);

    t_phase                 r_phase,     n_phase;
    logic [COL_W-1:0]       r_column,    n_column;
    logic                   r_prefix_ok, n_prefix_ok;
    t_num_stage             r_stage,     n_stage;
    logic                   r_neg,       n_neg;
    logic [ACC_W-1:0]       r_acc,       n_acc;
    logic                   r_len_valid, n_len_valid;
    logic [ACC_W-1:0]       r_len_value, n_len_value;
    logic [LENGTH_BITS-1:0] r_rem,       n_rem;

    logic [7:0]             w_c;
    logic                   w_is_digit;
    logic                   w_is_blank;
    logic                   w_is_sign;
    logic                   w_commit_ok;
    logic                   w_len_ok;
    logic [ACC_W-1:0]       w_acc_base;
    logic [MUL_W-1:0]       w_acc_mul;
    logic [ACC_W-1:0]       w_acc_next;
    logic [LENGTH_BITS-1:0] w_rem_dec;

    assign w_c        = i_item.in_byte;
    assign w_is_digit = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
    assign w_is_blank = (w_c == CHAR_SPACE) || (w_c == CHAR_TAB) ||
                        (w_c == CHAR_VT) || (w_c == CHAR_FF);
    assign w_is_sign  = (w_c == CHAR_PLUS) || (w_c == CHAR_MINUS);

    // A line's number counts if digits were seen and it is not a nonzero negative
    assign w_commit_ok = (r_stage == NS_DIGITS) && !(r_neg && (r_acc != '0));
    assign w_len_ok    = r_len_valid && !r_len_value[LENGTH_BITS];

    // Accumulate a decimal digit, saturating just above the cap
    assign w_acc_base = (r_stage == NS_DIGITS) ? r_acc : '0;
    assign w_acc_mul  = ({3'b000, w_acc_base} << 3) + ({3'b000, w_acc_base} << 1)
                      + MUL_W'(w_c[3:0]);
    assign w_acc_next = (w_acc_mul > MUL_SAT) ? ACC_SAT : w_acc_mul[ACC_W-1:0];

    // Body countdown
    assign w_rem_dec  = (r_rem != '0) ? (r_rem - LENGTH_BITS'(1)) : r_rem;

    assign o_phase = r_phase;

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_column    = r_column;
        n_prefix_ok = r_prefix_ok;
        n_stage     = r_stage;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_len_valid = r_len_valid;
        n_len_value = r_len_value;
        n_rem       = r_rem;
        if (i_take) begin
            priority if (i_item.stream_end) begin
                // Link closed: fresh header
                n_phase     = PH_HEADER;
                n_column    = '0;
                n_prefix_ok = 1'b1;
                n_stage     = NS_SKIP;
                n_neg       = 1'b0;
                n_acc       = '0;
                n_len_valid = 1'b0;
                n_len_value = '0;
                n_rem       = '0;
            end else if (r_phase == PH_BODY) begin
                // Count down body beats, back to header after the last one
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_phase     = PH_HEADER;
                    n_column    = '0;
                    n_prefix_ok = 1'b1;
                    n_stage     = NS_SKIP;
                    n_neg       = 1'b0;
                    n_acc       = '0;
                    n_len_valid = 1'b0;
                    n_len_value = '0;
                end
            end else if (w_c == CHAR_CR) begin
                // Drop CR
            end else if (w_c == CHAR_LF) begin
                if (r_column != '0) begin
                    // End of a header line: settle its length, clear line state
                    if (r_prefix_ok && (r_column >= PREFIX_COL)) begin
                        n_len_valid = w_commit_ok;
                        n_len_value = w_commit_ok ? r_acc : '0;
                    end
                    n_column    = '0;
                    n_prefix_ok = 1'b1;
                    n_stage     = NS_SKIP;
                    n_neg       = 1'b0;
                    n_acc       = '0;
                end else begin
                    // Empty line: header ends
                    n_phase     = PH_HEADER;
                    n_column    = '0;
                    n_prefix_ok = 1'b1;
                    n_stage     = NS_SKIP;
                    n_neg       = 1'b0;
                    n_acc       = '0;
                    n_len_valid = 1'b0;
                    n_len_value = '0;
                    n_rem       = '0;
                    if (w_len_ok && (r_len_value != '0)) begin
                        n_phase = PH_BODY;
                        n_rem   = r_len_value[LENGTH_BITS-1:0];
                    end
                end
            end else if (r_column < COL_LAST) begin
                // Ordinary line character
                n_column = r_column + COL_W'(1);
                priority if (r_column < PREFIX_COL) begin
                    if (r_prefix_ok &&
                        (to_lower(w_c) != prefix_char(r_column[PREFIX_IDX_W-1:0]))) begin
                        n_prefix_ok = 1'b0;
                    end
                end else if (!r_prefix_ok) begin
                    // Not a length line: ignore
                end else if (w_is_digit) begin
                    n_acc   = w_acc_next;
                    n_stage = NS_DIGITS;
                end else if ((r_stage == NS_SKIP) && w_is_blank) begin
                    // Skip leading blanks
                end else if ((r_stage == NS_SKIP) && w_is_sign) begin
                    n_neg   = (w_c == CHAR_MINUS);
                    n_stage = NS_SIGN;
                end else begin
                    // Parsing stops: fix the line's effect now
                    n_len_valid = w_commit_ok;
                    n_len_value = w_commit_ok ? r_acc : '0;
                    n_stage     = NS_STOP;
                    n_prefix_ok = 1'b0;
                end
            end else begin
                // Drop characters past the line limit
            end
        end
    end

    // Result of the current beat
    always_comb begin
        o_res_vld         = 1'b0;
        o_res.kind        = KIND_HDR_DONE;
        o_res.body_byte   = '0;
        o_res.body_length = '0;
        o_res.last        = 1'b0;
        if (i_take) begin
            priority if (i_item.stream_end) begin
                o_res_vld  = 1'b1;
                o_res.kind = KIND_STREAM_END;
            end else if (r_phase == PH_BODY) begin
                o_res_vld       = 1'b1;
                o_res.kind      = KIND_BODY;
                o_res.body_byte = w_c;
                o_res.last      = (w_rem_dec == '0);
            end else if ((w_c == CHAR_LF) && (r_column == '0)) begin
                o_res_vld = 1'b1;
                if (w_len_ok) begin
                    o_res.kind        = KIND_HDR_DONE;
                    o_res.body_length = r_len_value[LENGTH_BITS-1:0];
                    o_res.last        = (r_len_value == '0);
                end else begin
                    o_res.kind = KIND_BAD_LEN;
                end
            end else begin
                // Other header bytes give no result
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_column    <= '0;
            r_prefix_ok <= 1'b1;
            r_stage     <= NS_SKIP;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_len_valid <= 1'b0;
            r_len_value <= '0;
            r_rem       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_column    <= n_column;
            r_prefix_ok <= n_prefix_ok;
            r_stage     <= n_stage;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_len_valid <= n_len_valid;
            r_len_value <= n_len_value;
            r_rem       <= n_rem;
        end
    end

endmodule

[hdl/cld_out_stage.sv]
// ----------------------------------------------------------------------------
// cld_out_stage
// Result register: holds one result beat for the master side.
// ----------------------------------------------------------------------------
module cld_out_stage
    import cld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    // Room when empty or when the held beat is taken this cycle
    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
